/* sv/gcm_eng_pkg.sv */
// Shared types and constants of the GCM GHASH and counter-mode engine.
`timescale 1ns / 1ps
`default_nettype none

package gcm_eng_pkg;

    // Operation codes carried in the opcode field of an input item.
    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_AAD     = 3'd1;
    localparam logic [2:0] OP_ENCRYPT = 3'd2;
    localparam logic [2:0] OP_DECRYPT = 3'd3;
    localparam logic [2:0] OP_FINISH  = 3'd4;

    // Status codes returned with each result item.
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_NOT_OPEN    = 2'd1;
    localparam logic [1:0] STATUS_ALREADY_OPEN = 2'd2;

    // Register byte addresses on the configuration port.
    localparam int unsigned PADDR_W = 4;
    localparam logic [PADDR_W-1:0] ADDR_HASH_KEY_HIGH = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_HASH_KEY_LOW  = 4'h8;

    // Largest number of bytes in one block.
    localparam logic [4:0] BLOCK_BYTES = 5'd16;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic [63:0] stream_high;
        logic [63:0] stream_low;
        logic [4:0]  byte_count;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic        is_tag;
        logic [1:0]  status;
    } out_item_t;

endpackage

`default_nettype wire

/* sv/gcm_eng_gfmul.sv */
// Combinational GF(2^128) multiplier in the bit-reflected GCM convention.
`timescale 1ns / 1ps
`default_nettype none

module gcm_eng_gfmul (
    input  wire logic [127:0] op_a,
    input  wire logic [127:0] op_b,
    output logic      [127:0] product
);

    logic [127:0] a_rev;
    logic [127:0] b_rev;
    logic [254:0] full;
    logic [126:0] fold_hi;
    logic [133:0] fold1;
    logic [5:0]   fold_top;
    logic [127:0] reduced;

    // GCM puts the x^0 coefficient in the most significant bit, so the
    // operands are reversed into plain polynomial order first.
    always_comb begin
        for (int k = 0; k < 128; k++) begin
            a_rev[k] = op_a[127-k];
            b_rev[k] = op_b[127-k];
        end
    end

    // Carryless schoolbook product; each output bit is an XOR tree.
    always_comb begin
        full = '0;
        for (int i = 0; i < 128; i++) begin
            for (int j = 0; j < 128; j++) begin
                full[i+j] = full[i+j] ^ (a_rev[i] & b_rev[j]);
            end
        end
    end

    // Reduce modulo x^128 + x^7 + x^2 + x + 1 in two folds.
    assign fold_hi  = full[254:128];
    assign fold1    = {6'b0, full[127:0]}
                    ^ {7'b0, fold_hi}
                    ^ {6'b0, fold_hi, 1'b0}
                    ^ {5'b0, fold_hi, 2'b0}
                    ^ {fold_hi, 7'b0};
    assign fold_top = fold1[133:128];
    assign reduced  = fold1[127:0]
                    ^ {122'b0, fold_top}
                    ^ {121'b0, fold_top, 1'b0}
                    ^ {120'b0, fold_top, 2'b0}
                    ^ {115'b0, fold_top, 7'b0};

    always_comb begin
        for (int k = 0; k < 128; k++) begin
            product[k] = reduced[127-k];
        end
    end

endmodule

`default_nettype wire

/* sv/gcm_ghash_ctr_engine.sv */
// Top level of the GCM engine: item pipeline, hash state and configuration registers.
`timescale 1ns / 1ps
`default_nettype none

// GCM GHASH and counter-mode engine. The hash subkey H is written through the
// APB-style port (upper half at byte address 0, lower half at 8); the user must
// write it only while the block is idle, as the block does not enforce this.
// Each input item carries one operation: start opens a context and clears the
// accumulator and byte totals, an AAD item hashes up to 16 leading bytes,
// encrypt and decrypt XOR the block with the keystream supplied in the item
// and hash the ciphertext, and finish hashes the length block and returns the
// tag, E(K,Y0) XOR the accumulator. Every item yields exactly one result item
// carrying a status code. The AES core, counter generation and tag comparison
// live outside. An item is captured in an input register; from there a
// combinational 128-bit carryless multiplier updates the accumulator and the
// result is written to the output register once that register is free. A new
// item is accepted in every cycle while m_ready stays high, so throughput is
// one item per clock then. The critical path is the GF(2^128) multiplier and
// its reduction. The output register and the input register stall together
// only when the result side holds m_ready low.

module gcm_ghash_ctr_engine (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [gcm_eng_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [63:0]                       pwdata,
    output logic      [63:0]                       prdata,
    output logic                                   pready,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire gcm_eng_pkg::in_item_t             s_item,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output gcm_eng_pkg::out_item_t                 m_item
);

    // Configuration registers.
    logic [63:0] hash_key_high_reg;
    logic [63:0] hash_key_low_reg;

    // Pipeline registers.
    logic                   in_valid_reg;
    gcm_eng_pkg::in_item_t  in_item_reg;
    logic                   out_valid_reg;
    gcm_eng_pkg::out_item_t out_item_reg;

    // Hash context.
    logic [127:0] acc_reg;
    logic [127:0] acc_next;
    logic [31:0]  aad_total_reg;
    logic [31:0]  aad_total_next;
    logic [31:0]  data_total_reg;
    logic [31:0]  data_total_next;
    logic         open_reg;
    logic         open_next;

    gcm_eng_pkg::out_item_t result_next;

    logic         advance;
    logic [4:0]   count_sat;
    logic [127:0] byte_mask;
    logic [127:0] block_word;
    logic [127:0] stream_word;
    logic [127:0] text_word;
    logic [127:0] hash_in;
    logic [127:0] mult_in;
    logic [127:0] mult_out;

    // ------------------------------------------------------------------
    // Configuration port. pready is tied high; writes complete in the
    // access phase.
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_key_high_reg <= '0;
            hash_key_low_reg  <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr == gcm_eng_pkg::ADDR_HASH_KEY_HIGH) begin
                hash_key_high_reg <= pwdata;
            end
            if (paddr == gcm_eng_pkg::ADDR_HASH_KEY_LOW) begin
                hash_key_low_reg <= pwdata;
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == gcm_eng_pkg::ADDR_HASH_KEY_HIGH) begin
            prdata = hash_key_high_reg;
        end else if (paddr == gcm_eng_pkg::ADDR_HASH_KEY_LOW) begin
            prdata = hash_key_low_reg;
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The held item moves into the output register whenever the
    // output register is empty or its item is being taken this cycle, and
    // the input register refills in that same cycle.
    // ------------------------------------------------------------------
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= result_next;
        end
    end

    // ------------------------------------------------------------------
    // Datapath. Byte counts above sixteen behave as sixteen. The mask
    // keeps the leading bytes, byte 0 being the most significant.
    // ------------------------------------------------------------------
    assign count_sat = (in_item_reg.byte_count > gcm_eng_pkg::BLOCK_BYTES)
                     ? gcm_eng_pkg::BLOCK_BYTES : in_item_reg.byte_count;

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            byte_mask[127-8*k -: 8] = {8{5'(k) < count_sat}};
        end
    end

    assign block_word  = {in_item_reg.block_high, in_item_reg.block_low};
    assign stream_word = {in_item_reg.stream_high, in_item_reg.stream_low};
    assign text_word   = (block_word ^ stream_word) & byte_mask;

    // Ciphertext is what gets hashed: the output text when encrypting and
    // the input block when decrypting. Finish hashes the bit lengths.
    always_comb begin
        if (in_item_reg.opcode == gcm_eng_pkg::OP_ENCRYPT) begin
            hash_in = text_word;
        end else if (in_item_reg.opcode == gcm_eng_pkg::OP_FINISH) begin
            hash_in = {29'b0, aad_total_reg, 3'b0, 29'b0, data_total_reg, 3'b0};
        end else begin
            hash_in = block_word & byte_mask;
        end
    end

    assign mult_in = acc_reg ^ hash_in;

    gcm_eng_gfmul u_gfmul (
        .op_a    (mult_in),
        .op_b    ({hash_key_high_reg, hash_key_low_reg}),
        .product (mult_out)
    );

    // Next context and result for the item in the input register.
    always_comb begin
        acc_next        = acc_reg;
        aad_total_next  = aad_total_reg;
        data_total_next = data_total_reg;
        open_next       = open_reg;
        result_next     = '0;

        if (in_item_reg.opcode == gcm_eng_pkg::OP_START) begin
            if (open_reg) begin
                result_next.status = gcm_eng_pkg::STATUS_ALREADY_OPEN;
            end else begin
                acc_next        = '0;
                aad_total_next  = '0;
                data_total_next = '0;
                open_next       = 1'b1;
            end
        end else if (in_item_reg.opcode == gcm_eng_pkg::OP_AAD ||
                     in_item_reg.opcode == gcm_eng_pkg::OP_ENCRYPT ||
                     in_item_reg.opcode == gcm_eng_pkg::OP_DECRYPT ||
                     in_item_reg.opcode == gcm_eng_pkg::OP_FINISH) begin
            if (!open_reg) begin
                result_next.status = gcm_eng_pkg::STATUS_NOT_OPEN;
            end else begin
                acc_next = mult_out;
                if (in_item_reg.opcode == gcm_eng_pkg::OP_AAD) begin
                    aad_total_next = aad_total_reg + {27'b0, count_sat};
                end else if (in_item_reg.opcode == gcm_eng_pkg::OP_FINISH) begin
                    result_next.result_high = in_item_reg.stream_high ^ mult_out[127:64];
                    result_next.result_low  = in_item_reg.stream_low ^ mult_out[63:0];
                    result_next.is_tag      = 1'b1;
                    open_next               = 1'b0;
                end else begin
                    data_total_next         = data_total_reg + {27'b0, count_sat};
                    result_next.result_high = text_word[127:64];
                    result_next.result_low  = text_word[63:0];
                end
            end
        end
        // Unused opcodes leave the context alone and return an all-zero ok result.
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg        <= '0;
            aad_total_reg  <= '0;
            data_total_reg <= '0;
            open_reg       <= 1'b0;
        end else if (advance) begin
            acc_reg        <= acc_next;
            aad_total_reg  <= aad_total_next;
            data_total_reg <= data_total_next;
            open_reg       <= open_next;
        end
    end

endmodule

`default_nettype wire
